/* rtl/core/rrtd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rrtd_pkg;

    localparam int MAX_TASKS   = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int ID_W   = $clog2(MAX_TASKS);
    localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int TICK_W = 32;
    localparam int FUNC_W = 3;

    localparam int IN_W     = FUNC_W + ID_W;
    localparam int IN_BYTES = (IN_W + 7) / 8;
    localparam int IN_TW    = IN_BYTES * 8;

    localparam int OUT_W     = 1 + ID_W + TICK_W + CNT_W + LVL_W + 1;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;
    localparam int OUT_TW    = OUT_BYTES * 8;

    // bit positions inside the result beat
    localparam int OB_RUN_VALID = 0;
    localparam int OB_RUN_TASK  = 1;
    localparam int OB_TICK      = OB_RUN_TASK + ID_W;
    localparam int OB_LIVE      = OB_TICK + TICK_W;
    localparam int OB_LEVEL     = OB_LIVE + CNT_W;
    localparam int OB_OVF       = OB_LEVEL + LVL_W;

    typedef enum logic [FUNC_W-1:0] {
        F_DISPATCH  = 3'd0,
        F_YIELD     = 3'd1,
        F_BLOCK     = 3'd2,
        F_TERMINATE = 3'd3,
        F_SUSPEND   = 3'd4,
        F_RESUME    = 3'd5,
        F_CREATE    = 3'd6,
        F_DELETE    = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        SLOT_FREE    = 3'd0,
        SLOT_READY   = 3'd1,
        SLOT_RUN     = 3'd2,
        SLOT_BLOCKED = 3'd3,
        SLOT_STOPPED = 3'd4
    } t_tstate;

    typedef enum logic [2:0] {
        Q_NOP,
        Q_PUSH,
        Q_POP,
        Q_MARK,
        Q_COMPACT
    } t_q_op;

    typedef struct packed {
        t_q_op             op;
        logic [ID_W-1:0]   id;
    } t_q_cmd;

    typedef struct packed {
        logic [ID_W-1:0]   head_id;
        logic [LVL_W-1:0]  level;
        logic              full;
        logic              has_hole;
    } t_q_stat;

endpackage

`default_nettype wire

/* rtl/core/rrtd_queue_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module rrtd_queue_cell (
    input  wire logic                       i_clk,
    input  wire rrtd_pkg::t_q_cmd           i_cmd,
    input  wire logic                       i_sel_push,
    input  wire logic                       i_in_use,
    input  wire logic [rrtd_pkg::ID_W-1:0]  i_up_id,
    input  wire logic                       i_up_keep,
    input  wire logic                       i_hole_in,
    output logic      [rrtd_pkg::ID_W-1:0]  o_id,
    output logic                            o_keep,
    output logic                            o_hole_out
);

    logic [rrtd_pkg::ID_W-1:0] r_id;
    logic [rrtd_pkg::ID_W-1:0] n_id;
    logic                      r_keep;
    logic                      n_keep;

    // a hole is a purged entry still inside the used part of the row
    assign o_hole_out = i_hole_in | (i_in_use & ~r_keep);
    assign o_id       = r_id;
    assign o_keep     = r_keep;

    always_comb begin
        n_id   = r_id;
        n_keep = r_keep;
        unique case (i_cmd.op)
            rrtd_pkg::Q_POP: begin
                n_id   = i_up_id;
                n_keep = i_up_keep;
            end
            rrtd_pkg::Q_COMPACT: begin
                // everything from the lowest hole upward moves down one place
                if (o_hole_out) begin
                    n_id   = i_up_id;
                    n_keep = i_up_keep;
                end
            end
            rrtd_pkg::Q_MARK: begin
                if (i_in_use && (r_id == i_cmd.id)) begin
                    n_keep = 1'b0;
                end
            end
            rrtd_pkg::Q_PUSH: begin
                if (i_sel_push) begin
                    n_id   = i_cmd.id;
                    n_keep = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_keep <= n_keep;
    end

endmodule

`default_nettype wire

/* rtl/core/rrtd_ready_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module rrtd_ready_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rrtd_pkg::t_q_cmd  i_cmd,
    output rrtd_pkg::t_q_stat      o_stat
);

    localparam int D = rrtd_pkg::QUEUE_DEPTH;

    logic [rrtd_pkg::LVL_W-1:0] r_level;
    logic [rrtd_pkg::LVL_W-1:0] n_level;
    logic                       full;

    logic [rrtd_pkg::ID_W-1:0]  cell_id   [D+1];
    logic                       cell_keep [D+1];
    logic                       hole      [D+1];

    assign full = (r_level == rrtd_pkg::LVL_W'(D));

    // the slot above the top cell feeds in a harmless filler
    assign cell_id[D]   = '0;
    assign cell_keep[D] = 1'b1;
    assign hole[0]      = 1'b0;

    for (genvar g = 0; g < D; g++) begin : g_cell
        rrtd_queue_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (i_cmd),
            .i_sel_push (r_level == rrtd_pkg::LVL_W'(g)),
            .i_in_use   (r_level > rrtd_pkg::LVL_W'(g)),
            .i_up_id    (cell_id[g+1]),
            .i_up_keep  (cell_keep[g+1]),
            .i_hole_in  (hole[g]),
            .o_id       (cell_id[g]),
            .o_keep     (cell_keep[g]),
            .o_hole_out (hole[g+1])
        );
    end

    always_comb begin
        n_level = r_level;
        case (i_cmd.op) inside
            rrtd_pkg::Q_PUSH: begin
                if (!full) begin
                    n_level = r_level + 1'b1;
                end
            end
            rrtd_pkg::Q_POP, rrtd_pkg::Q_COMPACT: begin
                n_level = r_level - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    assign o_stat.head_id  = cell_id[0];
    assign o_stat.level    = r_level;
    assign o_stat.full     = full;
    assign o_stat.has_hole = hole[D];

endmodule

`default_nettype wire

/* rtl/core/round_robin_task_dispatcher_top.sv */
// Round-robin task dispatcher: non-preemptive scheduler over MAX_TASKS slots.
// Slave stream carries one event per beat: tdata[2:0] func, tdata[5:3] task_id.
// Master stream returns one status beat per event (fields listed at the port).
// Events are taken one at a time; the ready queue is a row of QUEUE_DEPTH
// cells that shift toward the head.
// Each event passes from S_IDLE to S_FIN, which registers the result beat:
//   yield, block, terminate, suspend, resume, create: straight to S_FIN
//   dispatch: via S_DISP, popping entries until a ready task is found or the
//             queue runs dry
//   delete: via S_PURGE, removing the task's entries one per cycle (free slot: direct)
// With a ready receiver the next event is taken on the edge that drains the
// result.
// A stalled receiver holds the result beat unchanged and keeps o_s_tready low
// until the beat is taken.
// Synchronous active-low reset: all slots free, queue empty, no task running,
// tick counter and live count cleared, no result pending. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_task_dispatcher_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // [2:0] func, [5:3] task_id, rest zero
    input  wire logic [rrtd_pkg::IN_TW-1:0]    i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [0] running_valid, [3:1] running_task, [35:4] tick_count,
    // [39:36] live_tasks, [44:40] queue_level, [45] queue_overflow, rest zero
    output logic      [rrtd_pkg::OUT_TW-1:0]   o_m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISP,
        S_PURGE,
        S_FIN
    } t_state;

    localparam int ID_W = rrtd_pkg::ID_W;

    t_state                          r_state;
    t_state                          n_state;
    rrtd_pkg::t_tstate               r_task_state [rrtd_pkg::MAX_TASKS];
    logic                            r_run_valid;
    logic                            n_run_valid;
    logic [ID_W-1:0]                 r_run_task;
    logic [ID_W-1:0]                 n_run_task;
    logic [rrtd_pkg::TICK_W-1:0]     r_tick;
    logic [rrtd_pkg::TICK_W-1:0]     n_tick;
    logic [rrtd_pkg::CNT_W-1:0]      r_live;
    logic [rrtd_pkg::CNT_W-1:0]      n_live;
    logic                            r_ovf;
    logic                            n_ovf;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic [rrtd_pkg::OUT_TW-1:0]     r_out_data;
    logic [rrtd_pkg::OUT_TW-1:0]     n_out_data;

    rrtd_pkg::t_func                 func;
    logic [ID_W-1:0]                 in_id;
    logic                            accept;
    logic [ID_W-1:0]                 ts_addr;
    rrtd_pkg::t_tstate               ts_rd;
    logic                            ts_we;
    rrtd_pkg::t_tstate               ts_wd;
    rrtd_pkg::t_q_cmd                q_cmd;
    rrtd_pkg::t_q_stat               q_stat;

    assign func   = rrtd_pkg::t_func'(i_s_tdata[rrtd_pkg::FUNC_W-1:0]);
    assign in_id  = i_s_tdata[rrtd_pkg::FUNC_W +: ID_W];
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept = i_s_tvalid && o_s_tready;

    // one state table port: the queue head while popping, else the slot in play
    always_comb begin
        if (r_state == S_DISP) begin
            ts_addr = q_stat.head_id;
        end else if ((func == rrtd_pkg::F_YIELD) || (func == rrtd_pkg::F_BLOCK) ||
                     (func == rrtd_pkg::F_TERMINATE)) begin
            ts_addr = r_run_task;
        end else begin
            ts_addr = in_id;
        end
    end

    assign ts_rd = r_task_state[ts_addr];

    rrtd_ready_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    always_comb begin
        n_state     = r_state;
        n_run_valid = r_run_valid;
        n_run_task  = r_run_task;
        n_tick      = r_tick;
        n_live      = r_live;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ts_we       = 1'b0;
        ts_wd       = rrtd_pkg::SLOT_FREE;
        q_cmd.op    = rrtd_pkg::Q_NOP;
        q_cmd.id    = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ovf   = 1'b0;
                    n_state = S_FIN;
                    unique case (func) inside
                        rrtd_pkg::F_DISPATCH: begin
                            n_tick      = r_tick + 1'b1;
                            n_run_valid = 1'b0;
                            n_run_task  = '0;
                            n_state     = S_DISP;
                        end
                        rrtd_pkg::F_YIELD: begin
                            if (r_run_valid) begin
                                if (ts_rd == rrtd_pkg::SLOT_RUN) begin
                                    ts_we    = 1'b1;
                                    ts_wd    = rrtd_pkg::SLOT_READY;
                                    q_cmd.op = rrtd_pkg::Q_PUSH;
                                    q_cmd.id = r_run_task;
                                    n_ovf    = q_stat.full;
                                end
                                n_run_valid = 1'b0;
                                n_run_task  = '0;
                            end
                        end
                        rrtd_pkg::F_BLOCK, rrtd_pkg::F_TERMINATE: begin
                            if (r_run_valid) begin
                                ts_we = 1'b1;
                                ts_wd = (func == rrtd_pkg::F_BLOCK)
                                        ? rrtd_pkg::SLOT_BLOCKED
                                        : rrtd_pkg::SLOT_STOPPED;
                                n_run_valid = 1'b0;
                                n_run_task  = '0;
                            end
                        end
                        rrtd_pkg::F_SUSPEND: begin
                            if ((ts_rd == rrtd_pkg::SLOT_RUN) ||
                                (ts_rd == rrtd_pkg::SLOT_READY)) begin
                                ts_we = 1'b1;
                                ts_wd = rrtd_pkg::SLOT_BLOCKED;
                            end
                        end
                        rrtd_pkg::F_RESUME: begin
                            if (ts_rd == rrtd_pkg::SLOT_BLOCKED) begin
                                ts_we    = 1'b1;
                                ts_wd    = rrtd_pkg::SLOT_READY;
                                q_cmd.op = rrtd_pkg::Q_PUSH;
                                q_cmd.id = in_id;
                                n_ovf    = q_stat.full;
                            end
                        end
                        rrtd_pkg::F_CREATE: begin
                            if (ts_rd == rrtd_pkg::SLOT_FREE) begin
                                ts_we    = 1'b1;
                                ts_wd    = rrtd_pkg::SLOT_READY;
                                q_cmd.op = rrtd_pkg::Q_PUSH;
                                q_cmd.id = in_id;
                                n_ovf    = q_stat.full;
                                n_live   = r_live + 1'b1;
                            end
                        end
                        rrtd_pkg::F_DELETE: begin
                            if (ts_rd != rrtd_pkg::SLOT_FREE) begin
                                ts_we    = 1'b1;
                                ts_wd    = rrtd_pkg::SLOT_FREE;
                                q_cmd.op = rrtd_pkg::Q_MARK;
                                q_cmd.id = in_id;
                                if (r_live != '0) begin
                                    n_live = r_live - 1'b1;
                                end
                                if (r_run_valid && (r_run_task == in_id)) begin
                                    n_run_valid = 1'b0;
                                    n_run_task  = '0;
                                end
                                n_state = S_PURGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DISP: begin
                // pop one entry a cycle, stale ones are simply dropped
                if (q_stat.level == '0) begin
                    n_state = S_FIN;
                end else begin
                    q_cmd.op = rrtd_pkg::Q_POP;
                    if (ts_rd == rrtd_pkg::SLOT_READY) begin
                        ts_we       = 1'b1;
                        ts_wd       = rrtd_pkg::SLOT_RUN;
                        n_run_valid = 1'b1;
                        n_run_task  = q_stat.head_id;
                        n_state     = S_FIN;
                    end
                end
            end
            S_PURGE: begin
                if (q_stat.has_hole) begin
                    q_cmd.op = rrtd_pkg::Q_COMPACT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_out_valid = 1'b1;
                n_out_data  = '0;
                n_out_data[rrtd_pkg::OB_RUN_VALID]               = r_run_valid;
                n_out_data[rrtd_pkg::OB_RUN_TASK +: ID_W]        = r_run_task;
                n_out_data[rrtd_pkg::OB_TICK +: rrtd_pkg::TICK_W] = r_tick;
                n_out_data[rrtd_pkg::OB_LIVE +: rrtd_pkg::CNT_W] = r_live;
                n_out_data[rrtd_pkg::OB_LEVEL +: rrtd_pkg::LVL_W] = q_stat.level;
                n_out_data[rrtd_pkg::OB_OVF]                     = r_ovf;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_valid <= 1'b0;
            r_run_task  <= '0;
            r_tick      <= '0;
            r_live      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < rrtd_pkg::MAX_TASKS; i++) begin
                r_task_state[i] <= rrtd_pkg::SLOT_FREE;
            end
        end else begin
            r_state     <= n_state;
            r_run_valid <= n_run_valid;
            r_run_task  <= n_run_task;
            r_tick      <= n_tick;
            r_live      <= n_live;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (ts_we) begin
                r_task_state[ts_addr] <= ts_wd;
            end
        end
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

/* rtl/core/rrtd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module rrtd_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    input  wire logic                          o_s_tready,
    input  wire logic                          o_m_tvalid,
    input  wire logic                          i_m_tready,
    input  wire logic [rrtd_pkg::OUT_TW-1:0]   o_m_tdata
);

    localparam int ID_W = rrtd_pkg::ID_W;

    // a stalled result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result beat changed under stall");

    // no running slot reported means task field is zero
    a_idle_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[rrtd_pkg::OB_RUN_VALID])
            |-> (o_m_tdata[rrtd_pkg::OB_RUN_TASK +: ID_W] == '0))
        else $error("running_task set with no task running");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            ((o_m_tdata[rrtd_pkg::OB_LIVE +: rrtd_pkg::CNT_W]
                <= rrtd_pkg::CNT_W'(rrtd_pkg::MAX_TASKS)) &&
             (o_m_tdata[rrtd_pkg::OB_LEVEL +: rrtd_pkg::LVL_W]
                <= rrtd_pkg::LVL_W'(rrtd_pkg::QUEUE_DEPTH))))
        else $error("live count or queue level out of range");

    // one event in flight: a taken event is never followed by another one
    // in the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("event taken while previous one still in progress");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat after reset");

endmodule

bind round_robin_task_dispatcher_top rrtd_checker u_rrtd_checker (.*);

`default_nettype wire

/* tb/tb_round_robin_task_dispatcher_top.sv */
`timescale 1ns / 1ps

module tb_round_robin_task_dispatcher_top;

    import rrtd_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int SEGMENT_LEN  = 25;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 27;
    localparam int DIR_ROWS     = 28;

    // status fields in the order they sit in the result beat
    typedef struct packed {
        logic              run_valid;
        logic [ID_W-1:0]   run_task;
        logic [TICK_W-1:0] ticks;
        logic [CNT_W-1:0]  live;
        logic [LVL_W-1:0]  level;
        logic              ovf;
    } t_status;

    typedef struct {
        t_func           f;
        logic [ID_W-1:0] id;
        bit              fill;
        bit              typed;
        t_status         want;
    } t_step;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [IN_TW-1:0]    i_s_tdata  = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [OUT_TW-1:0]   o_m_tdata;

    // scheduler model state
    t_tstate             slot_state [MAX_TASKS];
    logic [ID_W-1:0]     ready_q [$];
    logic                run_live = 1'b0;
    logic [ID_W-1:0]     run_id   = '0;
    logic [TICK_W-1:0]   ticks    = '0;
    logic [CNT_W-1:0]    live_cnt = '0;

    t_status             status_due [$];
    int                  fail_count  = 0;
    int                  sent_count  = 0;
    int                  cycle_count = 0;
    bit                  calm        = 1'b0;
    bit                  hold_req    = 1'b0;
    bit                  hold_taken  = 1'b0;
    int                  hold_left   = 0;

    round_robin_task_dispatcher_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic enqueue_ready(input logic [ID_W-1:0] id);
        if (ready_q.size() >= QUEUE_DEPTH)
            return 1'b1;
        ready_q.push_back(id);
        return 1'b0;
    endfunction

    function automatic t_status schedule_event(input t_func f, input logic [ID_W-1:0] id);
        logic            ovf;
        logic            was_running;
        logic [ID_W-1:0] cur;
        logic [ID_W-1:0] head;
        t_status         s;
        ovf         = 1'b0;
        was_running = run_live;
        cur         = run_id;
        case (f)
            F_DISPATCH: begin
                ticks    = ticks + 1'b1;
                run_live = 1'b0;
                run_id   = '0;
                // stale entries fall away on the way to the first ready task
                while (!run_live && ready_q.size() != 0) begin
                    head = ready_q.pop_front();
                    if (slot_state[head] == SLOT_READY) begin
                        slot_state[head] = SLOT_RUN;
                        run_live         = 1'b1;
                        run_id           = head;
                    end
                end
            end
            F_YIELD: begin
                if (was_running) begin
                    if (slot_state[cur] == SLOT_RUN) begin
                        slot_state[cur] = SLOT_READY;
                        ovf             = enqueue_ready(cur);
                    end
                    run_live = 1'b0;
                    run_id   = '0;
                end
            end
            F_BLOCK, F_TERMINATE: begin
                if (was_running) begin
                    if (f == F_BLOCK)
                        slot_state[cur] = SLOT_BLOCKED;
                    else
                        slot_state[cur] = SLOT_STOPPED;
                    run_live = 1'b0;
                    run_id   = '0;
                end
            end
            F_SUSPEND: begin
                if (slot_state[id] == SLOT_RUN || slot_state[id] == SLOT_READY)
                    slot_state[id] = SLOT_BLOCKED;
            end
            F_RESUME: begin
                if (slot_state[id] == SLOT_BLOCKED) begin
                    slot_state[id] = SLOT_READY;
                    ovf            = enqueue_ready(id);
                end
            end
            F_CREATE: begin
                if (slot_state[id] == SLOT_FREE) begin
                    slot_state[id] = SLOT_READY;
                    live_cnt       = live_cnt + 1'b1;
                    ovf            = enqueue_ready(id);
                end
            end
            F_DELETE: begin
                if (slot_state[id] != SLOT_FREE) begin
                    for (int n = ready_q.size() - 1; n >= 0; n--)
                        if (ready_q[n] == id)
                            ready_q.delete(n);
                    slot_state[id] = SLOT_FREE;
                    if (live_cnt != 0)
                        live_cnt = live_cnt - 1'b1;
                    if (was_running && cur == id) begin
                        run_live = 1'b0;
                        run_id   = '0;
                    end
                end
            end
        endcase
        s.run_valid = run_live;
        s.run_task  = run_id;
        s.ticks     = ticks;
        s.live      = live_cnt;
        s.level     = LVL_W'(ready_q.size());
        s.ovf       = ovf;
        return s;
    endfunction

    // status typed straight into the directed table, overflow always clear there
    function automatic t_status st(input bit v, input int t, input int tk,
                                   input int lv, input int lq);
        t_status s;
        s.run_valid = v;
        s.run_task  = ID_W'(t);
        s.ticks     = TICK_W'(tk);
        s.live      = CNT_W'(lv);
        s.level     = LVL_W'(lq);
        s.ovf       = 1'b0;
        return s;
    endfunction

    task automatic offer_event(input t_func f, input logic [ID_W-1:0] id,
                               input bit typed, input t_status want);
        t_status due;
        i_s_tdata  <= IN_TW'({id, f});
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        due = schedule_event(f, id);
        status_due.push_back(typed ? want : due);
        sent_count++;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [TICK_W-1:0] want,
                               input logic [TICK_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    initial begin : stimulus
        t_step       dir_steps [DIR_ROWS];
        t_status     no_want;
        bit          fill_done;
        int          mode;
        int          pick;
        int          k;
        // cumulative-free weights per event code: mixed, filling, draining
        int unsigned event_weight [3][8];

        no_want      = '0;
        event_weight = '{'{25, 13, 6, 4, 10, 12, 16, 14},
                         '{ 5, 15, 3, 2, 25, 30, 20,  0},
                         '{45, 10, 10, 10, 0,  0,  0, 25}};
        foreach (slot_state[n])
            slot_state[n] = SLOT_FREE;

        dir_steps = '{
            '{F_YIELD,     3'd0, 1'b0, 1'b1, st(0, 0, 0, 0, 0)},  // nothing running
            '{F_DISPATCH,  3'd0, 1'b0, 1'b1, st(0, 0, 1, 0, 0)},  // empty queue
            '{F_CREATE,    3'd0, 1'b0, 1'b1, st(0, 0, 1, 1, 1)},
            '{F_CREATE,    3'd0, 1'b0, 1'b1, st(0, 0, 1, 1, 1)},  // slot taken
            '{F_DISPATCH,  3'd0, 1'b0, 1'b1, st(1, 0, 2, 1, 0)},
            '{F_DELETE,    3'd0, 1'b0, 1'b1, st(0, 0, 2, 0, 0)},  // running task
            '{F_DELETE,    3'd0, 1'b0, 1'b1, st(0, 0, 2, 0, 0)},  // free slot
            '{F_CREATE,    3'd5, 1'b0, 1'b1, st(0, 0, 2, 1, 1)},
            '{F_DISPATCH,  3'd0, 1'b0, 1'b1, st(1, 5, 3, 1, 0)},
            '{F_TERMINATE, 3'd0, 1'b0, 1'b1, st(0, 0, 3, 1, 0)},
            '{F_CREATE,    3'd1, 1'b0, 1'b1, st(0, 0, 3, 2, 1)},
            '{F_CREATE,    3'd2, 1'b0, 1'b1, st(0, 0, 3, 3, 2)},
            '{F_DISPATCH,  3'd0, 1'b0, 1'b1, st(1, 1, 4, 3, 1)},
            '{F_DISPATCH,  3'd0, 1'b0, 1'b1, st(1, 2, 5, 3, 0)},  // pre-empts task 1
            '{F_SUSPEND,   3'd2, 1'b0, 1'b1, st(1, 2, 5, 3, 0)},  // keeps the slot
            '{F_YIELD,     3'd0, 1'b0, 1'b1, st(0, 0, 5, 3, 0)},  // blocked, no requeue
            '{F_RESUME,    3'd2, 1'b0, 1'b1, st(0, 0, 5, 3, 1)},
            '{F_BLOCK,     3'd0, 1'b0, 1'b1, st(0, 0, 5, 3, 1)},
            '{F_CREATE,    3'd7, 1'b0, 1'b1, st(0, 0, 5, 4, 2)},
            '{F_SUSPEND,   3'd7, 1'b0, 1'b1, st(0, 0, 5, 4, 2)},
            '{F_RESUME,    3'd7, 1'b0, 1'b1, st(0, 0, 5, 4, 3)},  // duplicate entry
            '{F_RESUME,    3'd7, 1'b1, 1'b0, no_want},           // fill past full
            '{F_DISPATCH,  3'd0, 1'b0, 1'b0, no_want},
            '{F_DELETE,    3'd7, 1'b0, 1'b0, no_want},           // long purge
            '{F_YIELD,     3'd0, 1'b0, 1'b0, no_want},
            '{F_DISPATCH,  3'd0, 1'b0, 1'b0, no_want},
            '{F_BLOCK,     3'd0, 1'b0, 1'b0, no_want},
            '{F_DELETE,    3'd1, 1'b0, 1'b0, no_want}            // running state, no slot
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_steps[n]) begin
            if (dir_steps[n].fill) begin
                // suspend and resume pairs until one resume finds the queue full
                fill_done = 1'b0;
                while (!fill_done) begin
                    fill_done = ready_q.size() >= QUEUE_DEPTH;
                    offer_event(F_SUSPEND, dir_steps[n].id, 1'b0, no_want);
                    offer_event(F_RESUME, dir_steps[n].id, 1'b0, no_want);
                end
            end else begin
                offer_event(dir_steps[n].f, dir_steps[n].id, dir_steps[n].typed,
                            dir_steps[n].want);
            end
        end

        mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                pick = $urandom_range(0, 99);
                mode = (pick < 70) ? 0 : (pick < 85) ? 1 : 2;
            end
            calm = (n >= 600 && n < 900);
            if (n == 1200)
                hold_req <= 1'b1;
            if (n == 1500) begin
                i_s_tvalid <= 1'b0;
                while (status_due.size() != 0)
                    @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            k    = 0;
            while (pick >= event_weight[mode][k]) begin
                pick -= event_weight[mode][k];
                k++;
            end
            offer_event(t_func'(k), ID_W'($urandom_range(0, MAX_TASKS - 1)), 1'b0, no_want);
        end

        i_s_tvalid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && status_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin : result_check
        t_status want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (status_due.size() == 0) begin
                $display("%0t ns: status beat with nothing expected, got %h", $time, o_m_tdata);
                fail_count++;
            end else begin
                want = status_due.pop_front();
                check_field("running_valid", TICK_W'(want.run_valid),
                            TICK_W'(o_m_tdata[OB_RUN_VALID]));
                check_field("running_task", TICK_W'(want.run_task),
                            TICK_W'(o_m_tdata[OB_RUN_TASK +: ID_W]));
                check_field("tick_count", want.ticks, o_m_tdata[OB_TICK +: TICK_W]);
                check_field("live_tasks", TICK_W'(want.live),
                            TICK_W'(o_m_tdata[OB_LIVE +: CNT_W]));
                check_field("queue_level", TICK_W'(want.level),
                            TICK_W'(o_m_tdata[OB_LEVEL +: LVL_W]));
                check_field("queue_overflow", TICK_W'(want.ovf),
                            TICK_W'(o_m_tdata[OB_OVF]));
            end
        end
        // one long hold-off so the block backs up and stalls its input
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
